// File: rtl/seg_int_pkg.sv
// Shared types and compare functions for the segment intersection pipeline.
// No dependencies; imported by seg_int_diff, seg_int_cross and the top level.
package seg_int_pkg;

    // Widest signed value any stage produces: cross products at 30-bit coordinates.
    localparam int WIDE_BITS  = 64;
    // Coordinates of up to 30 bits fit in one 32-bit signed word.
    localparam int COORD_MAX_BITS = 32;

    typedef logic signed [WIDE_BITS-1:0]      wide_t;
    typedef logic signed [COORD_MAX_BITS-1:0] coord_t;

    // Inclusive test that num lies between zero and den, direction set by the sign of den.
    function automatic logic within_range(input wide_t num, input wide_t den);
        logic res;
        if (den > 0) begin
            res = !(num < 0 || num > den);
        end else begin
            res = !(num > 0 || num < den);
        end
        return res;
    endfunction

    // Overlap of the span p0..p1 (either order) with the span q0..q1.
    function automatic logic spans_overlap(input coord_t p0, input coord_t p1,
                                           input coord_t q0, input coord_t q1);
        coord_t plo;
        coord_t phi;
        coord_t qlo;
        coord_t qhi;
        plo = (p0 < p1) ? p0 : p1;
        phi = (p0 < p1) ? p1 : p0;
        qlo = (q0 < q1) ? q0 : q1;
        qhi = (q0 < q1) ? q1 : q0;
        return !(phi < qlo || qhi < plo);
    endfunction

endpackage

// File: rtl/segment_intersection_test.sv
// Top level of the segment intersection test: four-stage pipeline of diff, mul, cross.
// Depends on seg_int_pkg, seg_int_diff, seg_int_mul and seg_int_cross.
//
// Usage: each input beat on the s_ channel carries the endpoints of two closed
// segments, A from (s_ax0,s_ay0) to (s_ax1,s_ay1) and B from (s_bx0,s_by0) to
// (s_bx1,s_by1), as signed COORD_BITS-bit values. Every input beat yields exactly
// one result beat on the m_ channel, whose m_hit is 1 when the segments share at
// least one point; touching endpoints and overlapping collinear segments count.
// The beat passes four registers, the first loaded at the edge that accepts it,
// and m_valid rises once the last holds it. Throughput is one beat per cycle
// unless m_ready stalls; the stages are difference and box test, six products, the
// three cross products, and the inclusive range decision, each ending in a register.
// Every stage carries its own valid bit and takes a new beat whenever it is empty
// or its successor is taking its current one, so bubbles close up while the
// receiver stalls and s_ready only drops once all four stages hold beats.
// A stalled result stays on m_hit unchanged until taken. Reset (aresetn low at a
// rising edge of aclk) empties the pipeline; results are in order and no state
// carries from one beat to the next.
module segment_intersection_test
    import seg_int_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_ax0,
    input  logic signed [COORD_BITS-1:0] s_ay0,
    input  logic signed [COORD_BITS-1:0] s_ax1,
    input  logic signed [COORD_BITS-1:0] s_ay1,
    input  logic signed [COORD_BITS-1:0] s_bx0,
    input  logic signed [COORD_BITS-1:0] s_by0,
    input  logic signed [COORD_BITS-1:0] s_bx1,
    input  logic signed [COORD_BITS-1:0] s_by1,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_hit
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    // Difference stage outputs.
    logic                 diff_valid;
    logic                 diff_ready;
    logic signed [DW-1:0] dax, day, dbx, dby, cx, cy;
    logic                 diff_box_ok;

    // Product stage outputs.
    logic                 mul_valid;
    logic                 mul_ready;
    logic signed [PW-1:0] f_pos, f_neg, d_pos, d_neg, e_pos, e_neg;
    logic                 mul_box_ok;

    // The bounding box test rides alongside the vectors so that the final stage
    // can reject pairs whose x or y ranges do not overlap.
    seg_int_diff #(
        .COORD_BITS (COORD_BITS)
    ) u_diff (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .ax0       (s_ax0),
        .ay0       (s_ay0),
        .ax1       (s_ax1),
        .ay1       (s_ay1),
        .bx0       (s_bx0),
        .by0       (s_by0),
        .bx1       (s_bx1),
        .by1       (s_by1),
        .out_valid (diff_valid),
        .out_ready (diff_ready),
        .dax       (dax),
        .day       (day),
        .dbx       (dbx),
        .dby       (dby),
        .cx        (cx),
        .cy        (cy),
        .box_ok    (diff_box_ok)
    );

    // Products are exact: each operand is COORD_BITS+1 bits, so at most 31 by 31.
    seg_int_mul #(
        .COORD_BITS (COORD_BITS)
    ) u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (diff_valid),
        .in_ready  (diff_ready),
        .dax       (dax),
        .day       (day),
        .dbx       (dbx),
        .dby       (dby),
        .cx        (cx),
        .cy        (cy),
        .box_ok_in (diff_box_ok),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .f_pos     (f_pos),
        .f_neg     (f_neg),
        .d_pos     (d_pos),
        .d_neg     (d_neg),
        .e_pos     (e_pos),
        .e_neg     (e_neg),
        .box_ok    (mul_box_ok)
    );

    // The last register of the cross stage doubles as the output register.
    seg_int_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mul_valid),
        .in_ready  (mul_ready),
        .f_pos     (f_pos),
        .f_neg     (f_neg),
        .d_pos     (d_pos),
        .d_neg     (d_neg),
        .e_pos     (e_pos),
        .e_neg     (e_neg),
        .box_ok_in (mul_box_ok),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .hit       (m_hit)
    );

endmodule

// File: rtl/seg_int_diff.sv
// First pipeline stage: edge and offset vectors plus the bounding box test.
// Depends on seg_int_pkg for the span overlap function.
module seg_int_diff
    import seg_int_pkg::*;
#(
    parameter int COORD_BITS = 16,
    localparam int DW = COORD_BITS + 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] ax0,
    input  logic signed [COORD_BITS-1:0] ay0,
    input  logic signed [COORD_BITS-1:0] ax1,
    input  logic signed [COORD_BITS-1:0] ay1,
    input  logic signed [COORD_BITS-1:0] bx0,
    input  logic signed [COORD_BITS-1:0] by0,
    input  logic signed [COORD_BITS-1:0] bx1,
    input  logic signed [COORD_BITS-1:0] by1,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DW-1:0]         dax,
    output logic signed [DW-1:0]         day,
    output logic signed [DW-1:0]         dbx,
    output logic signed [DW-1:0]         dby,
    output logic signed [DW-1:0]         cx,
    output logic signed [DW-1:0]         cy,
    output logic                         box_ok
);

    logic                 valid_reg;
    logic                 valid_next;
    logic signed [DW-1:0] dax_reg, day_reg, dbx_reg, dby_reg, cx_reg, cy_reg;
    logic                 box_ok_reg;
    logic                 box_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = in_ready ? in_valid : valid_reg;
        box_next   = spans_overlap(coord_t'(ax0), coord_t'(ax1), coord_t'(bx0), coord_t'(bx1))
                  && spans_overlap(coord_t'(ay0), coord_t'(ay1), coord_t'(by0), coord_t'(by1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            dax_reg    <= DW'(ax1) - DW'(ax0);
            day_reg    <= DW'(ay1) - DW'(ay0);
            dbx_reg    <= DW'(bx0) - DW'(bx1);
            dby_reg    <= DW'(by0) - DW'(by1);
            cx_reg     <= DW'(ax0) - DW'(bx0);
            cy_reg     <= DW'(ay0) - DW'(by0);
            box_ok_reg <= box_next;
        end
    end

    assign out_valid = valid_reg;
    assign dax       = dax_reg;
    assign day       = day_reg;
    assign dbx       = dbx_reg;
    assign dby       = dby_reg;
    assign cx        = cx_reg;
    assign cy        = cy_reg;
    assign box_ok    = box_ok_reg;

endmodule

// File: rtl/seg_int_mul.sv
// Second pipeline stage: the six signed products behind the three cross products.
// No package dependency; widths follow from COORD_BITS.
module seg_int_mul #(
    parameter int COORD_BITS = 16,
    localparam int DW = COORD_BITS + 1,
    localparam int PW = 2 * DW
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [DW-1:0] dax,
    input  logic signed [DW-1:0] day,
    input  logic signed [DW-1:0] dbx,
    input  logic signed [DW-1:0] dby,
    input  logic signed [DW-1:0] cx,
    input  logic signed [DW-1:0] cy,
    input  logic                 box_ok_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [PW-1:0] f_pos,
    output logic signed [PW-1:0] f_neg,
    output logic signed [PW-1:0] d_pos,
    output logic signed [PW-1:0] d_neg,
    output logic signed [PW-1:0] e_pos,
    output logic signed [PW-1:0] e_neg,
    output logic                 box_ok
);

    logic                 valid_reg;
    logic                 valid_next;
    logic signed [PW-1:0] f_pos_reg, f_neg_reg, d_pos_reg, d_neg_reg, e_pos_reg, e_neg_reg;
    logic                 box_ok_reg;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            f_pos_reg  <= PW'(day) * PW'(dbx);
            f_neg_reg  <= PW'(dax) * PW'(dby);
            d_pos_reg  <= PW'(dby) * PW'(cx);
            d_neg_reg  <= PW'(dbx) * PW'(cy);
            e_pos_reg  <= PW'(dax) * PW'(cy);
            e_neg_reg  <= PW'(day) * PW'(cx);
            box_ok_reg <= box_ok_in;
        end
    end

    assign out_valid = valid_reg;
    assign f_pos     = f_pos_reg;
    assign f_neg     = f_neg_reg;
    assign d_pos     = d_pos_reg;
    assign d_neg     = d_neg_reg;
    assign e_pos     = e_pos_reg;
    assign e_neg     = e_neg_reg;
    assign box_ok    = box_ok_reg;

endmodule

// File: rtl/seg_int_cross.sv
// Third and fourth pipeline stages: cross products f, d, e, then the range decision.
// Depends on seg_int_pkg for the inclusive range function.
module seg_int_cross
    import seg_int_pkg::*;
#(
    parameter int COORD_BITS = 16,
    localparam int PW = 2 * (COORD_BITS + 1),
    localparam int XW = PW + 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [PW-1:0] f_pos,
    input  logic signed [PW-1:0] f_neg,
    input  logic signed [PW-1:0] d_pos,
    input  logic signed [PW-1:0] d_neg,
    input  logic signed [PW-1:0] e_pos,
    input  logic signed [PW-1:0] e_neg,
    input  logic                 box_ok_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 hit
);

    logic                 sum_valid_reg;
    logic                 sum_valid_next;
    logic                 sum_ready;
    logic signed [XW-1:0] f_reg, d_reg, e_reg;
    logic                 box_ok_reg;

    logic                 hit_valid_reg;
    logic                 hit_valid_next;
    logic                 hit_reg;
    logic                 hit_next;

    assign sum_ready = !hit_valid_reg || out_ready;
    assign in_ready  = !sum_valid_reg || sum_ready;

    always_comb begin
        sum_valid_next = in_ready ? in_valid : sum_valid_reg;
        hit_valid_next = sum_ready ? sum_valid_reg : hit_valid_reg;
        hit_next       = box_ok_reg
                      && within_range(wide_t'(d_reg), wide_t'(f_reg))
                      && within_range(wide_t'(e_reg), wide_t'(f_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
            hit_valid_reg <= 1'b0;
        end else begin
            sum_valid_reg <= sum_valid_next;
            hit_valid_reg <= hit_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            f_reg      <= XW'(f_pos) - XW'(f_neg);
            d_reg      <= XW'(d_pos) - XW'(d_neg);
            e_reg      <= XW'(e_pos) - XW'(e_neg);
            box_ok_reg <= box_ok_in;
        end
        if (sum_valid_reg && sum_ready) begin
            hit_reg <= hit_next;
        end
    end

    assign out_valid = hit_valid_reg;
    assign hit       = hit_reg;

endmodule
